### rtl/fpss_pkg.sv
`timescale 1ns / 1ps

package fpss_pkg;

  // Q12 scale and saturation bound (plus or minus 9.0)
  localparam int unsigned QFrac = 12;
  localparam logic signed [31:0] QOne = 32'sd4096;
  localparam logic signed [31:0] QHalf = 32'sd2048;
  localparam logic signed [31:0] ClampHi = 32'sd36864;
  localparam logic signed [31:0] ClampLo = -32'sd36864;

  // Number of quotient bits produced by the divider chain
  localparam int unsigned NumCells = 13;

  typedef enum logic [1:0] {
    ACT_SIGMOID = 2'd0,
    ACT_SILU    = 2'd1,
    ACT_MUL     = 2'd2
  } fpss_action_e;

  // One division lane: operand, forced result, divisor, partial remainder, quotient
  typedef struct packed {
    logic [31:0] x;
    logic        frc;
    logic [12:0] fval;
    logic [13:0] den;
    logic [24:0] rem;
    logic [12:0] quo;
  } fpss_lane_t;

  // Item moving along the chain: lane 0 is x, lane 1 is the negated operand
  typedef struct packed {
    logic [1:0]            action;
    logic [31:0]           b;
    fpss_lane_t [1:0]      lane;
  } fpss_cell_t;

  // exp(-k) in Q12 at integer steps
  function automatic logic [12:0] exp_step(input logic [3:0] k);
    logic [12:0] v;
    case (k)
      4'd0: v = 13'd4096;
      4'd1: v = 13'd1507;
      4'd2: v = 13'd554;
      4'd3: v = 13'd204;
      4'd4: v = 13'd75;
      4'd5: v = 13'd28;
      4'd6: v = 13'd10;
      4'd7: v = 13'd4;
      4'd8: v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  // Divide by 4096, truncating toward zero
  function automatic logic signed [31:0] q_div(input logic signed [31:0] v);
    logic signed [31:0] adj;
    adj = v + (v[31] ? 32'sd4095 : 32'sd0);
    return adj >>> QFrac;
  endfunction

  // Remainder of the division above, sign of the dividend, sign-extended
  function automatic logic signed [31:0] q_rem(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = v - (q_div(v) <<< QFrac);
    return r;
  endfunction

endpackage

### rtl/fpss_div_cell.sv
`timescale 1ns / 1ps

module fpss_div_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  fpss_pkg::fpss_cell_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output fpss_pkg::fpss_cell_t data_o
);
  import fpss_pkg::*;

  logic       valid_q;
  logic       en;
  logic [25:0] trial [2];
  fpss_cell_t data_d, data_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // One restoring step per lane: quotient bit Shift
  always_comb begin
    data_d = data_i;
    for (int l = 0; l < 2; l++) begin
      trial[l] = 26'(data_i.lane[l].den) << Shift;
      if ({1'b0, data_i.lane[l].rem} >= trial[l]) begin
        data_d.lane[l].rem = data_i.lane[l].rem - trial[l][24:0];
        data_d.lane[l].quo[Shift] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  // Remainder stays below the divisor at this bit weight
  a_rem0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.lane[0].frc |->
      {1'b0, data_q.lane[0].rem} < (26'(data_q.lane[0].den) << Shift))
    else $error("lane 0 remainder out of range");
  a_rem1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.lane[1].frc |->
      {1'b0, data_q.lane[1].rem} < (26'(data_q.lane[1].den) << Shift))
    else $error("lane 1 remainder out of range");
  a_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.lane[0].frc |-> data_q.lane[0].den >= 14'd4096)
    else $error("divisor below one");

endmodule

### rtl/fixed_point_sigmoid_silu_unit.sv
`timescale 1ns / 1ps

// Q12 sigmoid / SiLU / multiply activation unit.
// Input channel s_axis: tuser carries the action (0 sigmoid, 1 silu, 2 multiply),
// tdata carries operand_a in [31:0] and operand_b in [63:32].
// Output channel m_axis: tdata carries the 32-bit result, one per input.
// From input transfer to tvalid an item passes three front stages
// (operand prep, exp table lookup, interpolation product), a chain of 13
// divider cells producing one quotient bit each, and four back stages
// (silu products, silu sum, multiply products, final sum).
// Throughput is one item per cycle while m_axis_tready is high; bubbles close
// up, as each stage holds one item and moves when the next is empty or moving.
// Two lanes run side by side so the multiply action gets silu(a) and
// silu(-a) in one pass.
// Reset clears all valid flags; payload registers are not reset.
// When m_axis_tready is low the result holds in the output register and the
// pipeline keeps filling; s_axis_tready drops only once every stage is full.
module fixed_point_sigmoid_silu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,   // action
  input  logic [63:0] s_axis_tdata_i,   // operand_a [31:0], operand_b [63:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // result
);
  import fpss_pkg::*;

  // Stage enables
  logic en0, en1, en2, en_b1, en_b2, en_b3, en_b4;

  // Stage 0: operands for both lanes
  logic               v0_q;
  logic [1:0]         act0_q;
  logic [31:0]        b0_q;
  logic [31:0]        x0_q [2];
  logic [31:0]        afp;

  // Stage 1: clamp flags and table values
  logic               v1_q;
  logic [1:0]         act1_q;
  logic [31:0]        b1_q;
  logic [31:0]        x1_q [2];
  logic               sh1_q [2];
  logic               sl1_q [2];
  logic               ze1_q [2];
  logic [12:0]        lo1_q [2];
  logic [11:0]        dm1_q [2];
  logic [11:0]        f1_q [2];
  logic [31:0]        t_abs [2];
  logic [12:0]        hi_v [2];
  logic [12:0]        lo_v [2];

  // Stage 2: interpolation product
  logic               v2_q;
  logic [1:0]         act2_q;
  logic [31:0]        b2_q;
  logic [31:0]        x2_q [2];
  logic               sh2_q [2];
  logic               sl2_q [2];
  logic               ze2_q [2];
  logic [12:0]        lo2_q [2];
  logic [23:0]        pr2_q [2];
  logic [12:0]        e_v [2];
  logic [13:0]        d_v [2];

  // Divider chain
  fpss_cell_t         cdat [NumCells+1];
  logic               cval [NumCells+1];
  logic               crdy [NumCells+1];

  // Back stages
  logic               vb1_q, vb2_q, vb3_q, vb4_q;
  logic [1:0]         actb1_q, actb2_q, actb3_q;
  logic [31:0]        bb1_q, bb2_q;
  logic [12:0]        sb1_q, sb2_q;
  logic signed [31:0] wh_q [2];
  logic signed [26:0] pt_q [2];
  logic signed [31:0] sil_q [2];
  logic signed [31:0] m1_q, m2_q, m3_q, m4_q;
  logic [31:0]        res3_q;
  logic [31:0]        res4_q;
  logic [12:0]        s_v [2];
  logic signed [31:0] qd_v [2];
  logic signed [31:0] qr_v [2];
  logic signed [31:0] nb_v;
  logic signed [31:0] part_v;

  // Ready chain from the output back to the input
  assign en_b4 = !vb4_q || m_axis_tready_i;
  assign en_b3 = !vb3_q || en_b4;
  assign en_b2 = !vb2_q || en_b3;
  assign en_b1 = !vb1_q || en_b2;
  assign en2   = !v2_q || crdy[0];
  assign en1   = !v1_q || en2;
  assign en0   = !v0_q || en1;
  assign s_axis_tready_o = en0;

  // Stage 0: scale a to Q12 for multiply, form lane operands
  assign afp = {s_axis_tdata_i[19:0], 12'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= s_axis_tvalid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      act0_q <= s_axis_tuser_i;
      b0_q   <= s_axis_tdata_i[63:32];
      x0_q[0] <= (s_axis_tuser_i == ACT_MUL) ? afp : s_axis_tdata_i[31:0];
      x0_q[1] <= 32'd0 - afp;
    end
  end

  // Stage 1: magnitude, saturation and table entries
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t_abs[l] = x0_q[l][31] ? 32'd0 - x0_q[l] : x0_q[l];
      lo_v[l]  = exp_step(t_abs[l][15:12]);
      hi_v[l]  = exp_step(t_abs[l][15:12] + 4'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      act1_q <= act0_q;
      b1_q   <= b0_q;
      for (int l = 0; l < 2; l++) begin
        x1_q[l]  <= x0_q[l];
        sh1_q[l] <= $signed(x0_q[l]) >= ClampHi;
        sl1_q[l] <= $signed(x0_q[l]) <= ClampLo;
        ze1_q[l] <= t_abs[l][15];
        lo1_q[l] <= lo_v[l];
        dm1_q[l] <= 12'(lo_v[l] - hi_v[l]);
        f1_q[l]  <= t_abs[l][11:0];
      end
    end
  end

  // Stage 2: slope times fraction
  always_ff @(posedge clk_i) begin
    if (en2) begin
      act2_q <= act1_q;
      b2_q   <= b1_q;
      for (int l = 0; l < 2; l++) begin
        x2_q[l]  <= x1_q[l];
        sh2_q[l] <= sh1_q[l];
        sl2_q[l] <= sl1_q[l];
        ze2_q[l] <= ze1_q[l];
        lo2_q[l] <= lo1_q[l];
        pr2_q[l] <= dm1_q[l] * f1_q[l];
      end
    end
  end

  // exp value, divisor and rounded dividend into the divider chain
  always_comb begin
    cdat[0].action = act2_q;
    cdat[0].b      = b2_q;
    for (int l = 0; l < 2; l++) begin
      e_v[l] = ze2_q[l] ? 13'd0 : lo2_q[l] - {1'b0, pr2_q[l][23:12]};
      d_v[l] = 14'd4096 + {1'b0, e_v[l]};
      cdat[0].lane[l].x    = x2_q[l];
      cdat[0].lane[l].quo  = 13'd0;
      cdat[0].lane[l].frc  = 1'b0;
      cdat[0].lane[l].fval = 13'd0;
      cdat[0].lane[l].den  = d_v[l];
      if (x2_q[l][31]) begin
        cdat[0].lane[l].rem = {e_v[l], 12'd0} + 25'(d_v[l] >> 1);
      end else begin
        cdat[0].lane[l].rem = 25'd16777216 + 25'(d_v[l] >> 1);
      end
      if (sh2_q[l]) begin
        cdat[0].lane[l].frc  = 1'b1;
        cdat[0].lane[l].fval = 13'd4096;
      end else if (sl2_q[l] || (x2_q[l][31] && e_v[l] == 13'd0)) begin
        cdat[0].lane[l].frc  = 1'b1;
      end
      if (cdat[0].lane[l].frc) begin
        cdat[0].lane[l].rem = 25'd0;
        cdat[0].lane[l].den = 14'd4096;
      end
    end
  end
  assign cval[0] = v2_q;

  // Divider chain, most significant quotient bit first
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fpss_div_cell #(
      .Shift(NumCells - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cval[i]),
      .ready_o(crdy[i]),
      .data_i (cdat[i]),
      .valid_o(cval[i+1]),
      .ready_i(crdy[i+1]),
      .data_o (cdat[i+1])
    );
  end
  assign crdy[NumCells] = en_b1;

  // B1: sigmoid value, silu integer and fraction products
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s_v[l]  = cdat[NumCells].lane[l].frc ? cdat[NumCells].lane[l].fval
                                           : cdat[NumCells].lane[l].quo;
      qd_v[l] = q_div($signed(cdat[NumCells].lane[l].x));
      qr_v[l] = q_rem($signed(cdat[NumCells].lane[l].x));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb1_q <= 1'b0;
      vb2_q <= 1'b0;
      vb3_q <= 1'b0;
      vb4_q <= 1'b0;
    end else begin
      if (en_b1) vb1_q <= cval[NumCells];
      if (en_b2) vb2_q <= vb1_q;
      if (en_b3) vb3_q <= vb2_q;
      if (en_b4) vb4_q <= vb3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b1) begin
      actb1_q <= cdat[NumCells].action;
      bb1_q   <= cdat[NumCells].b;
      sb1_q   <= s_v[0];
      for (int l = 0; l < 2; l++) begin
        wh_q[l] <= qd_v[l] * $signed({19'd0, s_v[l]});
        pt_q[l] <= $signed(qr_v[l][12:0]) * $signed({1'b0, s_v[l]});
      end
    end
  end

  // B2: silu = whole + rounded fraction
  always_ff @(posedge clk_i) begin
    if (en_b2) begin
      actb2_q <= actb1_q;
      bb2_q   <= bb1_q;
      sb2_q   <= sb1_q;
      for (int l = 0; l < 2; l++) begin
        sil_q[l] <= wh_q[l] + q_div(32'(pt_q[l]) + QHalf);
      end
    end
  end

  // B3: multiply partial products against b and -b
  assign nb_v = 32'sd0 - $signed(bb2_q);

  always_ff @(posedge clk_i) begin
    if (en_b3) begin
      actb3_q <= actb2_q;
      m1_q    <= q_div(sil_q[0]) * $signed(bb2_q);
      m2_q    <= q_div(sil_q[1]) * nb_v;
      m3_q    <= q_rem(sil_q[0]) * $signed(bb2_q);
      m4_q    <= q_rem(sil_q[1]) * nb_v;
      case (actb2_q)
        ACT_SIGMOID: res3_q <= {19'd0, sb2_q};
        ACT_SILU:    res3_q <= sil_q[0];
        default:     res3_q <= 32'd0;
      endcase
    end
  end

  // B4: output register
  assign part_v = q_div(m3_q + m4_q + QHalf);

  always_ff @(posedge clk_i) begin
    if (en_b4) begin
      if (actb3_q == ACT_MUL) begin
        res4_q <= m1_q + m2_q + part_v;
      end else begin
        res4_q <= res3_q;
      end
    end
  end

  assign m_axis_tvalid_o = vb4_q;
  assign m_axis_tdata_o  = res4_q;

  // Input stalls only when the output is holding a result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled with output free");
  // Sigmoid never exceeds one
  a_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb3_q && actb3_q == ACT_SIGMOID |-> res3_q <= 32'd4096)
    else $error("sigmoid above one");
  // Unused action code gives zero
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb3_q && actb3_q != ACT_SIGMOID && actb3_q != ACT_SILU && actb3_q != ACT_MUL
      |-> res3_q == 32'd0)
    else $error("unused action gave nonzero");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fpss_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [1:0]  s_axis_tuser_i;   // action
  logic [63:0] s_axis_tdata_i;   // operand_a [31:0], operand_b [63:32]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // result

  fixed_point_sigmoid_silu_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles = 40;
  localparam logic signed [31:0] QNine = 32'sd36864;
  // Action code with no operation assigned
  localparam logic [1:0] ActUnused = 2'd3;

  logic signed [31:0] pending_results[$];
  int  error_count;
  int  idle_count;
  bit  idle_en;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Q12 helpers: C-style truncating divide and remainder by 4096
  function automatic logic signed [31:0] q12_quot(input logic signed [31:0] v);
    longint t;
    t = v;
    return 32'(t / 4096);
  endfunction

  function automatic logic signed [31:0] q12_frac(input logic signed [31:0] v);
    longint t;
    t = v;
    return 32'(t % 4096);
  endfunction

  // exp(-t) from the integer-step table with linear interpolation
  function automatic logic signed [31:0] exp_interp(input logic signed [31:0] t);
    logic signed [31:0] steps[10];
    logic signed [31:0] k, f, lo, hi;
    steps = '{4096, 1507, 554, 204, 75, 28, 10, 4, 1, 0};
    if (t <= 0) return 32'sd4096;
    if (t >= QNine) return 32'sd0;
    k = t / 4096;
    if (k >= 8) return 32'sd0;
    f = t - k * 4096;
    lo = steps[k];
    hi = steps[k + 1];
    return lo + ((hi - lo) * f) / 4096;
  endfunction

  function automatic logic signed [31:0] sigmoid_q12(input logic signed [31:0] x);
    logic signed [31:0] e, d;
    if (x >= QNine) return 32'sd4096;
    if (x <= -QNine) return 32'sd0;
    if (x >= 0) begin
      e = exp_interp(x);
      d = 4096 + e;
      return (32'sd16777216 + d / 2) / d;
    end
    e = exp_interp(-x);
    if (e == 0) return 32'sd0;
    d = e + 4096;
    return (e * 4096 + d / 2) / d;
  endfunction

  // x * sigmoid(x) in split integer and fraction parts, 32-bit wrap
  function automatic logic signed [31:0] silu_q12(input logic signed [31:0] x);
    logic signed [31:0] s, whole, part;
    s = sigmoid_q12(x);
    whole = q12_quot(x) * s;
    part = q12_quot(q12_frac(x) * s + 32'sd2048);
    return whole + part;
  endfunction

  function automatic logic signed [31:0] mul_via_silu(input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
    logic signed [31:0] afp, sp, sn, nb, whole, part;
    afp = a * 32'sd4096;
    sp = silu_q12(afp);
    sn = silu_q12(-afp);
    nb = -b;
    whole = q12_quot(sp) * b + q12_quot(sn) * nb;
    part = q12_quot(q12_frac(sp) * b + q12_frac(sn) * nb + 32'sd2048);
    return whole + part;
  endfunction

  function automatic logic signed [31:0] activation_result(input logic [1:0] act,
      input logic signed [31:0] a, input logic signed [31:0] b);
    case (act)
      ACT_SIGMOID: return sigmoid_q12(a);
      ACT_SILU:    return silu_q12(a);
      ACT_MUL:     return mul_via_silu(a, b);
      default:     return 32'sd0;
    endcase
  endfunction

  // Send one item, with an optional idle burst before it
  task automatic send_item(input logic [1:0] act, input logic signed [31:0] a,
                           input logic signed [31:0] b);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(activation_result(act, a, b));
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_all_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_q12_near();
    // inside the interesting range of +-10.0
    return $signed($urandom_range(0, 2 * 40960)) - 32'sd40960;
  endfunction

  // Directed: extremes, every action, clamps and table end
  task automatic test_directed();
    logic signed [31:0] pts[12];
    pts = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, QNine, -QNine, QNine - 1,
            -QNine + 1, 32'sd32768, -32'sd32768, 32'sd4096};
    foreach (pts[i]) send_item(ACT_SIGMOID, pts[i], 32'sd0);
    send_item(ACT_SILU, 32'sh7fffffff, 0);
    send_item(ACT_SILU, 32'sh80000000, 0);
    send_item(ACT_SILU, -32'sd6000, 0);
    send_item(ACT_MUL, 7, -3);
    send_item(ACT_MUL, -5, 9);
    send_item(ACT_MUL, 32'sh7fffffff, 32'sh80000000);
    send_item(ACT_MUL, 32'sh80000000, 32'sh7fffffff);
    send_item(ACT_MUL, 0, 32'shffffffff);
    send_item(ActUnused, 32'sh12345678, 32'shffffffff);
    send_item(ActUnused, 32'shffffffff, 32'sh0);
  endtask

  // Hold off the sender until the pipeline has fully drained
  task automatic test_drain_pause();
    send_item(ACT_SILU, 32'sd8192, 0);
    wait_all_results();
    send_item(ACT_MUL, 3, 4);
  endtask

  task automatic test_random(input int count);
    logic [1:0] act;
    logic signed [31:0] a, b;
    for (int i = 0; i < count; i++) begin
      act = 2'($urandom_range(0, 3));
      a = $urandom_range(0, 1) ? rand_q12_near() : $urandom();
      b = $urandom();
      if (act == ACT_MUL && $urandom_range(0, 1)) begin
        a = $signed($urandom_range(0, 40)) - 32'sd20;
        b = $signed($urandom_range(0, 2000)) - 32'sd1000;
      end
      send_item(act, a, b);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata_o);
        error_count++;
      end else begin
        if (m_axis_tdata_o !== pending_results[0]) begin
          $display("%0t: result mismatch expected %h actual %h", $time,
                   pending_results[0], m_axis_tdata_o);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Output backpressure in random bursts
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      if (idle_en) repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_count = 0;
    idle_en = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i = '0;
    s_axis_tdata_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_drain_pause();
    test_random(700);
    idle_en = 1'b0;
    test_random(200);
    wait_all_results();
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
